/* rtl/csl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes, tables and helper functions of the C subset lexer.
package csl_pkg;

   // Longest letter run kept for keyword matching, and columns added per tab.
   localparam int MAX_KEYWORD_LEN = 6;
   localparam int TAB_WIDTH       = 4;

   // Keyword table: text padded with zeros, and the length of each keyword.
   localparam int KW_COUNT    = 5;
   localparam int KW_TEXT_LEN = 6;
   localparam int KW_CMP_LEN  = (MAX_KEYWORD_LEN < KW_TEXT_LEN) ? MAX_KEYWORD_LEN : KW_TEXT_LEN;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_TEXT_LEN] = '{
      '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h66},   // printf
      '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},   // int
      '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00},   // float
      '{8'h64, 8'h6F, 8'h75, 8'h62, 8'h6C, 8'h65},   // double
      '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00}    // void
   };
   localparam int KW_LEN [KW_COUNT] = '{6, 3, 5, 6, 4};

   // Single-character symbols in detail-index order: { } [ ] ( ) ; , =
   localparam int SYM_COUNT = 9;
   localparam logic [7:0] SYM_TEXT [SYM_COUNT] = '{
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h3B, 8'h2C, 8'h3D
   };

   // Item function codes.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   // Token kind codes.
   localparam logic [2:0] KIND_KEYWORD = 3'd0;
   localparam logic [2:0] KIND_NUMBER  = 3'd1;
   localparam logic [2:0] KIND_IDENT   = 3'd2;
   localparam logic [2:0] KIND_LITERAL = 3'd3;
   localparam logic [2:0] KIND_SYMBOL  = 3'd4;
   localparam logic [2:0] KIND_ERROR   = 3'd5;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic       func;
      logic [7:0] source_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [7:0]  token_detail;
      logic [15:0] token_row;
      logic [15:0] token_column;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   // Results of one processed item, in order: tok0 first, tok1 second.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    tok0;
      rsp_type    tok1;
   } step_out_type;

   // Saturating 16-bit add.
   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] d);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, d};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

/* rtl/csl_core.sv */
`timescale 1ns / 1ps
// Scanner state registers and the single-pass step logic for one item.
module csl_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  csl_pkg::req_type      item,
   output csl_pkg::step_out_type step_out
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_LETTERS = 3'd1;
   localparam logic [2:0] MODE_IDENT   = 3'd2;
   localparam logic [2:0] MODE_NUMBER  = 3'd3;
   localparam logic [2:0] MODE_LITERAL = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  buf_ff [csl_pkg::MAX_KEYWORD_LEN];
   logic        ovf_ff, ovf_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] srow_ff, srow_in;
   logic [15:0] scol_ff, scol_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [csl_pkg::MAX_KEYWORD_LEN-1:0] buf_we;

   logic [7:0]  b;
   logic        is_alpha, is_digit, is_under, is_quote, is_space, is_sym;
   logic [7:0]  sym_idx;
   logic        kw_hit;
   logic [7:0]  kw_idx;
   logic        kw_eq;
   logic        pend_emit, do_fresh, fresh_emit;
   csl_pkg::rsp_type pend_tok, fresh_tok;

   assign b        = item.source_byte;
   assign is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   assign is_digit = (b >= 8'h30 && b <= 8'h39);
   assign is_under = (b == CH_UNDER);
   assign is_quote = (b == CH_QUOTE);
   assign is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                     (b == CH_CR) || (b == CH_NUL);

   always_comb begin
      is_sym  = 1'b0;
      sym_idx = '0;
      for (int i = 0; i < csl_pkg::SYM_COUNT; i++) begin
         if (!is_sym && b == csl_pkg::SYM_TEXT[i]) begin
            is_sym  = 1'b1;
            sym_idx = 8'(i);
         end
      end
   end

   // Parallel compare of the letter buffer against every keyword; first hit wins.
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = '0;
      kw_eq  = 1'b0;
      for (int k = 0; k < csl_pkg::KW_COUNT; k++) begin
         kw_eq = !ovf_ff && (len_ff == 16'(csl_pkg::KW_LEN[k])) &&
                 (csl_pkg::KW_LEN[k] <= csl_pkg::MAX_KEYWORD_LEN);
         for (int j = 0; j < csl_pkg::KW_CMP_LEN; j++) begin
            if (j < csl_pkg::KW_LEN[k] && buf_ff[j] != csl_pkg::KW_TEXT[k][j]) begin
               kw_eq = 1'b0;
            end
         end
         if (!kw_hit && kw_eq) begin
            kw_hit = 1'b1;
            kw_idx = 8'(k);
         end
      end
   end

   // Token that the pending run gives when it ends.
   always_comb begin
      pend_tok              = '0;
      pend_tok.token_row    = srow_ff;
      pend_tok.token_column = scol_ff;
      pend_tok.token_length = len_ff;
      case (mode_ff)
         MODE_LETTERS: begin
            pend_tok.token_kind   = kw_hit ? csl_pkg::KIND_KEYWORD : csl_pkg::KIND_IDENT;
            pend_tok.token_detail = kw_hit ? kw_idx : 8'd0;
         end
         MODE_IDENT:   pend_tok.token_kind = csl_pkg::KIND_IDENT;
         MODE_NUMBER:  pend_tok.token_kind = csl_pkg::KIND_NUMBER;
         MODE_LITERAL: pend_tok.token_kind = csl_pkg::KIND_LITERAL;
         default:      pend_tok.token_kind = csl_pkg::KIND_IDENT;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      ovf_in     = ovf_ff;
      len_in     = len_ff;
      srow_in    = srow_ff;
      scol_in    = scol_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      buf_we     = '0;
      pend_emit  = 1'b0;
      do_fresh   = 1'b0;
      fresh_emit = 1'b0;
      fresh_tok  = '0;

      if (item.func == csl_pkg::FUNC_END) begin
         pend_emit = (mode_ff == MODE_LETTERS) || (mode_ff == MODE_IDENT) ||
                     (mode_ff == MODE_NUMBER) || (mode_ff == MODE_LITERAL);
         mode_in   = MODE_IDLE;
      end else begin
         if (b == CH_LF) begin
            col_in = '0;
            row_in = csl_pkg::sat_add16(row_ff, 16'd1);
         end else if (b == CH_TAB) begin
            col_in = csl_pkg::sat_add16(col_ff, 16'(csl_pkg::TAB_WIDTH));
         end else begin
            col_in = csl_pkg::sat_add16(col_ff, 16'd1);
         end

         case (mode_ff)
            MODE_LETTERS: begin
               if (is_alpha) begin
                  if (len_ff < 16'(csl_pkg::MAX_KEYWORD_LEN)) begin
                     for (int i = 0; i < csl_pkg::MAX_KEYWORD_LEN; i++) begin
                        buf_we[i] = (len_ff == 16'(i));
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
                  len_in = csl_pkg::sat_add16(len_ff, 16'd1);
               end else if ((is_digit || is_under) && !kw_hit) begin
                  mode_in = MODE_IDENT;
                  len_in  = csl_pkg::sat_add16(len_ff, 16'd1);
               end else begin
                  pend_emit = 1'b1;
                  do_fresh  = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_alpha || is_digit || is_under) begin
                  len_in = csl_pkg::sat_add16(len_ff, 16'd1);
               end else begin
                  pend_emit = 1'b1;
                  do_fresh  = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  len_in = csl_pkg::sat_add16(len_ff, 16'd1);
               end else begin
                  pend_emit = 1'b1;
                  do_fresh  = 1'b1;
               end
            end
            MODE_LITERAL: begin
               if (is_quote) begin
                  pend_emit = 1'b1;
                  mode_in   = MODE_IDLE;
               end else begin
                  len_in = csl_pkg::sat_add16(len_ff, 16'd1);
               end
            end
            default: begin
               do_fresh = 1'b1;
            end
         endcase

         // The byte starts afresh: a new run, a one-byte token, or nothing.
         if (do_fresh) begin
            mode_in                = MODE_IDLE;
            fresh_tok.token_row    = row_in;
            fresh_tok.token_column = col_in;
            fresh_tok.token_length = 16'd1;
            if (is_alpha || is_digit || is_under || is_quote) begin
               ovf_in  = 1'b0;
               srow_in = row_in;
               scol_in = col_in;
               len_in  = is_quote ? 16'd0 : 16'd1;
               if (is_alpha) begin
                  mode_in   = MODE_LETTERS;
                  buf_we[0] = 1'b1;
               end else if (is_digit) begin
                  mode_in = MODE_NUMBER;
               end else if (is_under) begin
                  mode_in = MODE_IDENT;
               end else begin
                  mode_in = MODE_LITERAL;
               end
            end else if (is_sym) begin
               fresh_emit             = 1'b1;
               fresh_tok.token_kind   = csl_pkg::KIND_SYMBOL;
               fresh_tok.token_detail = sym_idx;
            end else if (!is_space) begin
               fresh_emit             = 1'b1;
               fresh_tok.token_kind   = csl_pkg::KIND_ERROR;
               fresh_tok.token_detail = b;
            end
         end
      end
   end

   always_comb begin
      step_out       = '0;
      step_out.count = {1'b0, pend_emit} + {1'b0, fresh_emit};
      step_out.tok0  = pend_emit ? pend_tok : fresh_tok;
      step_out.tok0.last_of_run = !(pend_emit && fresh_emit);
      step_out.tok1  = fresh_tok;
      step_out.tok1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         ovf_ff  <= 1'b0;
         len_ff  <= '0;
         srow_ff <= 16'd1;
         scol_ff <= '0;
         row_ff  <= 16'd1;
         col_ff  <= '0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         ovf_ff  <= ovf_in;
         len_ff  <= len_in;
         srow_ff <= srow_in;
         scol_ff <= scol_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < csl_pkg::MAX_KEYWORD_LEN; i++) begin
         if (step_en && buf_we[i]) begin
            buf_ff[i] <= b;
         end
      end
   end

endmodule

/* rtl/csl_fifo.sv */
`timescale 1ns / 1ps
// Result queue that takes up to two tokens per cycle and hands out one per cycle while rsp_stall is low.
module csl_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  csl_pkg::step_out_type push_data,
   output logic                  room_for_two,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output csl_pkg::rsp_type      rsp_data
);

   csl_pkg::rsp_type mem_ff [csl_pkg::FIFO_DEPTH];
   logic [csl_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [csl_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [csl_pkg::FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic [csl_pkg::FIFO_CNT_W-1:0] cnt_after_pop;
   logic [csl_pkg::FIFO_CNT_W-1:0] push_cnt;
   logic                           pop;

   assign rsp_valid     = (cnt_ff != '0);
   assign rsp_data      = mem_ff[rd_ptr_ff];
   assign pop           = rsp_valid && !rsp_stall;
   assign cnt_after_pop = cnt_ff - csl_pkg::FIFO_CNT_W'(pop);
   assign room_for_two  = (cnt_after_pop <= csl_pkg::FIFO_CNT_W'(csl_pkg::FIFO_DEPTH - 2));
   assign push_cnt      = push_en ? csl_pkg::FIFO_CNT_W'(push_data.count) : '0;

   always_comb begin
      cnt_in    = cnt_after_pop + push_cnt;
      wr_ptr_in = wr_ptr_ff + csl_pkg::FIFO_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + csl_pkg::FIFO_PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != '0) begin
         mem_ff[wr_ptr_ff] <= push_data.tok0;
      end
      if (push_cnt == csl_pkg::FIFO_CNT_W'(2)) begin
         mem_ff[wr_ptr_ff + csl_pkg::FIFO_PTR_W'(1)] <= push_data.tok1;
      end
   end

endmodule

/* rtl/c_subset_lexer_top.sv */
`timescale 1ns / 1ps
// An item waits in the input register, then its tokens go to the result queue.
// Throughput: one item per cycle while the queue has room; the result port moves
// one token per cycle while rsp_stall is low, so items that give two tokens drain
// at that port's rate through a four-entry queue.
// Reset (synchronous, active high) empties the input register and result queue,
// sets the scanner idle and places the position at row 1, column 0.
module c_subset_lexer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  csl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output csl_pkg::rsp_type rsp_data
);

   // The input register holds one accepted item until the result queue has
   // room for the two tokens it may produce.
   csl_pkg::req_type     item_ff;
   logic                 item_vld_ff, item_vld_in;
   logic                 room_for_two;
   logic                 process;
   logic                 req_accept;
   csl_pkg::step_out_type step_out;

   // The held item is scanned in the same cycle that it leaves the register,
   // so a new transfer can be taken every cycle while the queue has room.
   assign process    = item_vld_ff && room_for_two;
   assign req_stall  = item_vld_ff && !room_for_two;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_accept) begin
         item_vld_in = 1'b1;
      end else if (process) begin
         item_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
   end

   // Scanner: position tracking, token state and keyword/symbol matching.
   csl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (process),
      .item     (item_ff),
      .step_out (step_out)
   );

   // Result queue: pushes zero, one or two tokens, pops one per transfer.
   csl_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_en      (process),
      .push_data    (step_out),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
